/* design/pmpf_pkg.sv */
// Shared types and constants of the moire palette filter.
// Coefficient sets, phase table, beat formats and the structs between modules.
// No dependencies.
package pmpf_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
    localparam int SUBPIXELS   = 3;
    localparam int DIV_STEPS   = 8;

    localparam int Y_W   = 23;   // luma, units 2^-14, always positive
    localparam int UV_W  = 23;   // signed chroma, units 2^-14
    localparam int F_W   = 24;   // signed moire numerator
    localparam int C_W   = 40;   // signed rebuilt channel, units 2^-28
    localparam int REM_W = 31;   // divider remainder

    localparam logic [1:0] LAST_SUB = 2'(SUBPIXELS - 1);

    // chroma scaling: floor(x / 200) done as floor((x >> 3) / 25), x offset to positive
    localparam logic signed [33:0] HUE_OFFSET = 34'sd1677721600;  // 200 * 2^23
    localparam logic signed [25:0] HUE_BIAS   = 26'sd8388608;     // 2^23
    localparam logic [29:0]        RECIP_25   = 30'd687194768;    // ceil(2^34 / 25)

    // request kinds carried on s_tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_HUE   = 2'd0;
    localparam logic [1:0] CFG_BT709 = 2'd1;
    localparam logic [1:0] CFG_MONO  = 2'd2;

    typedef logic signed [16:0] coef_t;

    typedef struct packed {
        coef_t yr, yg, yb;
        coef_t ur, ug, ub;
        coef_t vr, vg, vb;
        coef_t krv, kgu, kgv, kbu;
    } coefs_t;

    localparam coefs_t COEF_601 = '{
        17'sd4899, 17'sd9617, 17'sd1868,
        -17'sd2411, -17'sd4732, 17'sd7143,
        17'sd10076, -17'sd8437, -17'sd1639,
        17'sd18675, 17'sd6466, 17'sd9513, 17'sd33294};

    localparam coefs_t COEF_709 = '{
        17'sd3483, 17'sd11718, 17'sd1183,
        -17'sd1637, -17'sd5506, 17'sd7143,
        17'sd10076, -17'sd9152, -17'sd924,
        17'sd20977, 17'sd3520, 17'sd6236, 17'sd34866};

    typedef enum logic [1:0] {
        SEL_PU,
        SEL_MU,
        SEL_PV,
        SEL_MV
    } moire_sel_t;

    localparam moire_sel_t PHASE_SEL [16] = '{
        SEL_PV, SEL_PU, SEL_MV, SEL_MU,
        SEL_MV, SEL_PU, SEL_PV, SEL_MU,
        SEL_MV, SEL_MU, SEL_PV, SEL_PU,
        SEL_PV, SEL_MU, SEL_MV, SEL_PU};

    typedef struct packed {
        logic       valid;
        logic [1:0] sub;
        logic       last;
    } side_t;

    typedef struct packed {
        side_t      side;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] phase;
    } issue_t;

    typedef struct packed {
        side_t                  side;
        logic [Y_W-1:0]         y;
        logic [2:0][REM_W-1:0]  rem;
        logic [2:0][7:0]        quo;
        logic [2:0]             neg;
        logic [2:0]             sat;
    } div_t;

endpackage

/* design/pmpf_front.sv */
// Palette memory and subpixel issue: stores entries, reads a pixel's entry and
// issues its three subpixels, one per cycle while the pipeline advances. Depends on pmpf_pkg.
module pmpf_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [55:0]     s_tdata,   // entry_index, red_in, green_in, blue_in, column, row
    input  logic            s_tuser,   // req_type
    output pmpf_pkg::issue_t issue
);
    import pmpf_pkg::*;

    logic [23:0]          pal_mem [PAL_ENTRIES];
    logic [23:0]          rgb_reg;
    logic                 hold_reg, hold_next;
    logic [1:0]           sub_reg, sub_next;
    logic [7:0]           col_reg;
    logic [1:0]           row_reg;
    logic                 accept, acc_pixel, acc_write, emit;
    logic [PAL_IDX_W-1:0] idx;
    logic [3:0]           col3;

    assign idx       = s_tdata[PAL_IDX_W-1:0];
    assign s_tready  = adv && (!hold_reg || sub_reg == LAST_SUB);
    assign accept    = s_tvalid && s_tready;
    assign acc_pixel = accept && s_tuser == REQ_PIXEL;
    assign acc_write = accept && s_tuser == REQ_WRITE;
    assign emit      = hold_reg && adv;

    always_ff @(posedge aclk) begin
        if (acc_write) begin
            pal_mem[idx] <= s_tdata[31:8];
        end
        if (acc_pixel) begin
            rgb_reg <= pal_mem[idx];
        end
    end

    always_comb begin
        hold_next = hold_reg;
        sub_next  = sub_reg;
        if (emit) begin
            if (sub_reg == LAST_SUB) begin
                hold_next = 1'b0;
                sub_next  = 2'd0;
            end else begin
                sub_next = sub_reg + 2'd1;
            end
        end
        if (acc_pixel) begin
            hold_next = 1'b1;
            sub_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
            sub_reg  <= 2'd0;
        end else begin
            hold_reg <= hold_next;
            sub_reg  <= sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_pixel) begin
            col_reg <= s_tdata[39:32];
            row_reg <= s_tdata[41:40];
        end
    end

    // (3 * column + subpixel) & 3
    assign col3 = 4'(col_reg[1:0]) * 4'd3 + 4'(sub_reg);

    always_comb begin
        issue.side.valid = hold_reg;
        issue.side.sub   = sub_reg;
        issue.side.last  = (sub_reg == LAST_SUB);
        issue.red        = rgb_reg[7:0];
        issue.green      = rgb_reg[15:8];
        issue.blue       = rgb_reg[23:16];
        issue.phase      = {row_reg, col3[1:0]};
    end

endmodule

/* design/pmpf_color_pipe.sv */
// Color arithmetic pipeline: YUV conversion, chroma gain, rebuild, moire
// product and rounding offset, ending in the divider head. Depends on pmpf_pkg.
module pmpf_color_pipe (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic [7:0]       hue,
    input  logic             bt709,
    input  logic             mono,
    input  pmpf_pkg::issue_t issue,
    output pmpf_pkg::div_t   head
);
    import pmpf_pkg::*;

    coefs_t kk;
    logic [7:0] h;

    side_t side_reg [1:8];
    logic [Y_W-1:0] y_reg [2:8];
    logic signed [F_W-1:0] f_reg [3:6];

    // stage 1
    logic [7:0] red1_reg, green1_reg, blue1_reg;
    logic [3:0] phase1_reg;
    // stage 2
    logic [Y_W-1:0] y2_next;
    logic signed [UV_W-1:0] u2_reg, u2_next, v2_reg, v2_next;
    moire_sel_t sel2_reg, sel2_next;
    logic uvz2_reg, uvz2_next;
    // stage 3
    logic [28:0] tu3_reg, tu3_next, tv3_reg, tv3_next;
    logic signed [F_W-1:0] f3_next;
    // stage 4
    logic [58:0] mu4_reg, mu4_next, mv4_reg, mv4_next;
    // stage 5
    logic signed [C_W-1:0] prv5_reg, prv5_next, pgu5_reg, pgu5_next;
    logic signed [C_W-1:0] pgv5_reg, pgv5_next, pbu5_reg, pbu5_next;
    // stage 6
    logic signed [C_W-1:0] c6_reg [3];
    logic signed [C_W-1:0] c6_next [3];
    // stage 7
    logic signed [44:0] plo7_reg [3];
    logic signed [44:0] plo7_next [3];
    logic signed [43:0] phi7_reg [3];
    logic signed [43:0] phi7_next [3];
    // stage 8
    logic signed [37:0] n8_reg [3];
    logic signed [37:0] n8_next [3];
    div_t head_reg, head_next;

    assign kk = bt709 ? COEF_709 : COEF_601;
    assign h  = mono ? 8'd0 : hue;

    // stage 2: Y, U, V
    always_comb begin
        logic signed [8:0]  r9, g9, b9;
        logic signed [27:0] y_full, u_full, v_full;
        r9 = $signed({1'b0, red1_reg});
        g9 = $signed({1'b0, green1_reg});
        b9 = $signed({1'b0, blue1_reg});
        y_full = kk.yr * r9 + kk.yg * g9 + kk.yb * b9;
        u_full = kk.ur * r9 + kk.ug * g9 + kk.ub * b9;
        v_full = kk.vr * r9 + kk.vg * g9 + kk.vb * b9;
        // black forces Y to one
        y2_next   = (y_full == 28'sd0) ? Y_W'(16384) : y_full[Y_W-1:0];
        u2_next   = u_full[UV_W-1:0];
        v2_next   = v_full[UV_W-1:0];
        uvz2_next = (u_full == 28'sd0) && (v_full == 28'sd0);
        sel2_next = PHASE_SEL[phase1_reg];
    end

    // stage 3: offset chroma products for the divide by 200, moire numerator
    always_comb begin
        logic signed [8:0]  h9;
        logic signed [33:0] xu, xv;
        logic signed [F_W-1:0] ye;
        h9 = $signed({1'b0, h});
        xu = u2_reg * h9 * 2 + 34'sd100 + HUE_OFFSET;
        xv = v2_reg * h9 * 2 + 34'sd100 + HUE_OFFSET;
        tu3_next = xu[31:3];
        tv3_next = xv[31:3];
        ye = $signed({1'b0, y_reg[2]});
        if (uvz2_reg) begin
            f3_next = ye;
        end else begin
            case (sel2_reg)
                SEL_PU:  f3_next = ye + u2_reg;
                SEL_MU:  f3_next = ye - u2_reg;
                SEL_PV:  f3_next = ye + v2_reg;
                SEL_MV:  f3_next = ye - v2_reg;
                default: f3_next = ye;
            endcase
        end
    end

    // stage 4: reciprocal of 25
    assign mu4_next = {30'b0, tu3_reg} * {29'b0, RECIP_25};
    assign mv4_next = {30'b0, tv3_reg} * {29'b0, RECIP_25};

    // stage 5: scaled chroma times rebuild gains
    always_comb begin
        logic signed [25:0] us_w, vs_w;
        logic signed [23:0] us, vs;
        us_w = $signed({1'b0, mu4_reg[58:34]}) - HUE_BIAS;
        vs_w = $signed({1'b0, mv4_reg[58:34]}) - HUE_BIAS;
        us = us_w[23:0];
        vs = vs_w[23:0];
        prv5_next = kk.krv * vs;
        pgu5_next = kk.kgu * us;
        pgv5_next = kk.kgv * vs;
        pbu5_next = kk.kbu * us;
    end

    // stage 6: channels R, G, B
    always_comb begin
        logic signed [C_W-1:0] base;
        base = $signed({3'b0, y_reg[5], 14'b0});
        c6_next[0] = base + prv5_reg;
        c6_next[1] = base - pgu5_reg - pgv5_reg;
        c6_next[2] = base + pbu5_reg;
    end

    // stage 7: channel times numerator, split in two partial products
    always_comb begin
        logic signed [20:0] lo;
        logic signed [19:0] hi;
        for (int ch = 0; ch < 3; ch++) begin
            lo = $signed({1'b0, c6_reg[ch][19:0]});
            hi = c6_reg[ch][C_W-1:20];
            plo7_next[ch] = lo * f_reg[6];
            phi7_next[ch] = hi * f_reg[6];
        end
    end

    // stage 8: add half the divisor, drop the 2^28 part of it
    always_comb begin
        logic signed [65:0] pe, he, ye, sum;
        ye = $signed({16'b0, y_reg[7], 27'b0});
        for (int ch = 0; ch < 3; ch++) begin
            pe = plo7_reg[ch];
            he = phi7_reg[ch];
            sum = (he <<< 20) + pe + ye;
            n8_next[ch] = sum[65:28];
        end
    end

    // divider head: negative and overflow flags, remainder start
    always_comb begin
        logic signed [37:0] lim;
        lim = $signed({7'b0, y_reg[8], 8'b0});
        head_next.side = side_reg[8];
        head_next.y    = y_reg[8];
        head_next.quo  = '0;
        for (int ch = 0; ch < 3; ch++) begin
            head_next.neg[ch] = n8_reg[ch][37];
            head_next.sat[ch] = !n8_reg[ch][37] && (n8_reg[ch] >= lim);
            head_next.rem[ch] = n8_reg[ch][REM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= 8; i++) begin
                side_reg[i] <= '0;
            end
            head_reg <= '0;
        end else if (adv) begin
            side_reg[1] <= issue.side;
            for (int i = 2; i <= 8; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            head_reg <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            red1_reg   <= issue.red;
            green1_reg <= issue.green;
            blue1_reg  <= issue.blue;
            phase1_reg <= issue.phase;
            y_reg[2]   <= y2_next;
            for (int i = 3; i <= 8; i++) begin
                y_reg[i] <= y_reg[i-1];
            end
            u2_reg   <= u2_next;
            v2_reg   <= v2_next;
            sel2_reg <= sel2_next;
            uvz2_reg <= uvz2_next;
            tu3_reg  <= tu3_next;
            tv3_reg  <= tv3_next;
            f_reg[3] <= f3_next;
            for (int i = 4; i <= 6; i++) begin
                f_reg[i] <= f_reg[i-1];
            end
            mu4_reg  <= mu4_next;
            mv4_reg  <= mv4_next;
            prv5_reg <= prv5_next;
            pgu5_reg <= pgu5_next;
            pgv5_reg <= pgv5_next;
            pbu5_reg <= pbu5_next;
            for (int ch = 0; ch < 3; ch++) begin
                c6_reg[ch]   <= c6_next[ch];
                plo7_reg[ch] <= plo7_next[ch];
                phi7_reg[ch] <= phi7_next[ch];
                n8_reg[ch]   <= n8_next[ch];
            end
        end
    end

    assign head = head_reg;

endmodule

/* design/pmpf_div_cell.sv */
// One cell of the divider chain: one quotient bit for each of the three
// channels, restoring step against Y * 2^7. Depends on pmpf_pkg.
module pmpf_div_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  pmpf_pkg::div_t din,
    output pmpf_pkg::div_t dout
);
    import pmpf_pkg::*;

    div_t dout_reg, dout_next;

    always_comb begin
        logic [REM_W-1:0] d, diff;
        d = {1'b0, din.y, 7'b0};
        dout_next = din;
        for (int ch = 0; ch < 3; ch++) begin
            diff = din.rem[ch] - d;
            if (din.rem[ch] >= d) begin
                dout_next.rem[ch] = {diff[REM_W-2:0], 1'b0};
                dout_next.quo[ch] = {din.quo[ch][6:0], 1'b1};
            end else begin
                dout_next.rem[ch] = {din.rem[ch][REM_W-2:0], 1'b0};
                dout_next.quo[ch] = {din.quo[ch][6:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dout_reg <= '0;
        end else if (adv) begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

/* design/pal_moire_palette_filter.sv */
// A pixel beat passes the front's entry register, the color pipeline, the 8-cell divider
// chain and the output register; its three subpixel beats then leave on m_* in order.
// The three subpixels share one color pipeline and one 8-cell divider chain; the next
// pixel beat is taken as the last subpixel issues. Palette writes give no beat. Reset
// (aresetn low, synchronous) empties the pipeline and sets hue 100, BT.601, color;
// palette contents are kept. Top level; depends on pmpf_pkg, pmpf_front, pmpf_color_pipe, pmpf_div_cell.
module pal_moire_palette_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // entry_index, red_in, green_in, blue_in, column, row
    input  logic        s_tuser,    // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // color
    output logic [1:0]  m_tuser,    // subpixel
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import pmpf_pkg::*;

    logic       adv;
    logic [7:0] hue_reg;
    logic       bt709_reg, mono_reg;
    issue_t     issue;
    div_t       chain [DIV_STEPS+1];
    logic       m_tvalid_reg, m_tvalid_next;
    logic [23:0] color_reg, color_next;
    logic [1:0] sub_reg;
    logic       last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_reg   <= 8'd100;
            bt709_reg <= 1'b0;
            mono_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HUE:   hue_reg   <= cfg_data;
                CFG_BT709: bt709_reg <= cfg_data[0];
                CFG_MONO:  mono_reg  <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    // whole pipe moves when the output register is free or being drained
    assign adv = !m_tvalid_reg || m_tready;

    pmpf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .issue    (issue)
    );

    pmpf_color_pipe u_pipe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .hue     (hue_reg),
        .bt709   (bt709_reg),
        .mono    (mono_reg),
        .issue   (issue),
        .head    (chain[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
        pmpf_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .din     (chain[i]),
            .dout    (chain[i+1])
        );
    end

    always_comb begin
        logic [7:0] val;
        color_next    = '0;
        m_tvalid_next = chain[DIV_STEPS].side.valid;
        for (int ch = 0; ch < 3; ch++) begin
            if (chain[DIV_STEPS].neg[ch]) begin
                val = 8'd0;
            end else if (chain[DIV_STEPS].sat[ch]) begin
                val = 8'd255;
            end else begin
                val = chain[DIV_STEPS].quo[ch];
            end
            color_next[ch*8 +: 8] = val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            color_reg <= color_next;
            sub_reg   <= chain[DIV_STEPS].side.sub;
            last_reg  <= chain[DIV_STEPS].side.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = color_reg;
    assign m_tuser  = sub_reg;
    assign m_tlast  = last_reg;

endmodule

/* test/tb.sv */
// Self-checking bench for pal_moire_palette_filter: palette writes and pixel beats on s_*,
// subpixel colors checked on m_* against a local fixed-point predictor.
// Depends on pmpf_pkg and the design sources.
`timescale 1ns / 1ps

module tb;
    import pmpf_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] col;
        logic [8:0] row;
    } req_t;

    typedef struct packed {
        logic [23:0] color;
        logic [1:0]  sub;
        logic        last;
    } sub_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    pal_moire_palette_filter i_dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    req_t      pending_reqs[$];
    sub_beat_t expected_subs[$];
    logic [23:0] pal_shadow[256];
    bit        pal_written[256];
    int        hue_pct = 100;
    bit        bt709 = 1'b0;
    bit        mono = 1'b0;
    int        err_count = 0;
    int        pixel_count = 0;
    int        sub_count = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    bit        cfg_pending = 1'b0;
    logic [1:0] cfg_idx_q;
    logic [7:0] cfg_val_q;

    localparam int WATCHDOG = 5000;

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint rdiv(longint n, longint d);
        return floor_div(2 * n + d, 2 * d);
    endfunction

    function automatic logic [7:0] to_byte(longint c, longint f, longint y);
        longint v;
        v = rdiv(c * f, y * 64'd268435456);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic logic [23:0] moire_color(logic [23:0] rgb, logic [3:0] phase);
        coefs_t k;
        longint r, g, b, y, u, v, h, us, vs, base, f;
        moire_sel_t sel;
        logic [7:0] cr, cg, cb;
        k = bt709 ? COEF_709 : COEF_601;
        r = rgb[7:0];
        g = rgb[15:8];
        b = rgb[23:16];
        y = k.yr * r + k.yg * g + k.yb * b;
        u = k.ur * r + k.ug * g + k.ub * b;
        v = k.vr * r + k.vg * g + k.vb * b;
        h = mono ? 0 : hue_pct;
        sel = PHASE_SEL[phase];
        if (y == 0) y = 16384;
        us = rdiv(u * h, 100);
        vs = rdiv(v * h, 100);
        base = y * 16384;
        if (u == 0 && v == 0) f = y;
        else case (sel)
            SEL_PU: f = y + u;
            SEL_MU: f = y - u;
            SEL_PV: f = y + v;
            default: f = y - v;
        endcase
        cr = to_byte(base + k.krv * vs, f, y);
        cg = to_byte(base - k.kgu * us - k.kgv * vs, f, y);
        cb = to_byte(base + k.kbu * us, f, y);
        return {cb, cg, cr};
    endfunction

    // state update and expectations, applied at acceptance
    task automatic predict_pixel(req_t rq);
        logic [3:0] phase;
        sub_beat_t e;
        if (rq.kind == REQ_WRITE) begin
            pal_shadow[rq.idx] = {rq.blue, rq.green, rq.red};
            return;
        end
        for (int s = 0; s < SUBPIXELS; s++) begin
            phase = {rq.row[1:0], 2'(3 * rq.col + s)};
            e.color = moire_color(pal_shadow[rq.idx], phase);
            e.sub = 2'(s);
            e.last = (s == SUBPIXELS - 1);
            expected_subs.push_back(e);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        req_t rq;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_pixel(pending_reqs.pop_front());
            end
            if (!(s_tvalid && !s_tready)) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (pending_reqs.size() > 0 && gap_left == 0) begin
                    rq = pending_reqs[0];
                    s_tvalid <= 1'b1;
                    s_tuser <= rq.kind;
                    s_tdata <= {7'b0, rq.row, rq.col, rq.blue, rq.green, rq.red, rq.idx};
                    burst_left--;
                end else begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0 && burst_left == 0) gap_left--;
                    else if (gap_left > 0) burst_left = 0;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HUE: hue_pct = cfg_data;
                    CFG_BT709: bt709 = cfg_data[0];
                    CFG_MONO: mono = cfg_data[0];
                    default: ;
                endcase
                cfg_valid <= 1'b0;
                cfg_pending = 1'b0;
            end else if (cfg_pending) begin
                cfg_valid <= 1'b1;
                cfg_index <= cfg_idx_q;
                cfg_data <= cfg_val_q;
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge aclk) begin
        sub_beat_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sub_count++;
                if (expected_subs.size() == 0) begin
                    $error("unexpected subpixel beat color=%h", m_tdata);
                    err_count++;
                end else begin
                    e = expected_subs.pop_front();
                    if (m_tdata !== e.color) begin
                        $error("color exp %h got %h", e.color, m_tdata);
                        err_count++;
                    end
                    if (m_tuser !== e.sub) begin
                        $error("subpixel exp %0d got %0d", e.sub, m_tuser);
                        err_count++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last exp %0d got %0d", e.last, m_tlast);
                        err_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || (pending_reqs.size() == 0 && expected_subs.size() == 0 && !cfg_pending))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog expired");
                $display("TB_ERROR");
                $finish;
            end
            case ((sub_count / 40) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 1) == 0) || (sub_count % 7 == 0);
            endcase
        end
    end

    function automatic req_t mk_write(int i, int r, int g, int b);
        req_t rq;
        rq = '{kind: REQ_WRITE, idx: 8'(i), red: 8'(r), green: 8'(g), blue: 8'(b),
               col: 8'($urandom), row: 9'($urandom)};
        return rq;
    endfunction

    function automatic req_t mk_pixel(int i, int c, int rw);
        req_t rq;
        rq = '{kind: REQ_PIXEL, idx: 8'(i), red: 8'($urandom), green: 8'($urandom),
               blue: 8'($urandom), col: 8'(c), row: 9'(rw)};
        return rq;
    endfunction

    task automatic queue_req(req_t rq);
        if (rq.kind == REQ_WRITE) pal_written[rq.idx] = 1'b1;
        else pixel_count++;
        pending_reqs.push_back(rq);
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_subs.size() == 0);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        cfg_idx_q = idx;
        cfg_val_q = 8'(val);
        cfg_pending = 1'b1;
        wait (!cfg_pending);
        @(posedge aclk);
    endtask

    // random phase: writes and pixels from written entries only
    task automatic random_items(int n);
        int i;
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(0, 4) == 0) begin
                queue_req(mk_write($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 255)));
            end else begin
                do i = $urandom_range(0, 255); while (!pal_written[i]);
                queue_req(mk_pixel(i, $urandom_range(0, 255), $urandom_range(0, 511)));
            end
        end
    endtask

    initial begin
        int hues[5] = '{0, 100, 200, 255, 37};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: black, white, grey, primaries, extreme positions
        queue_req(mk_write(0, 0, 0, 0));
        queue_req(mk_write(255, 255, 255, 255));
        queue_req(mk_write(1, 128, 128, 128));
        queue_req(mk_write(2, 255, 0, 0));
        queue_req(mk_write(3, 0, 255, 0));
        queue_req(mk_write(4, 0, 0, 255));
        queue_req(mk_write(5, 255, 255, 0));
        queue_req(mk_write(6, 0, 255, 255));
        for (int i = 0; i < 7; i++)
            queue_req(mk_pixel(i, (i & 1) ? 255 : 0, (i & 2) ? 511 : i));
        queue_req(mk_pixel(255, 255, 511));
        for (int rw = 0; rw < 4; rw++)
            queue_req(mk_pixel(2, rw, rw));
        queue_req(mk_write(2, 10, 200, 90));
        queue_req(mk_pixel(2, 170, 85));
        for (int i = 7; i < 40; i++)
            queue_req(mk_write(i, $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255)));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_HUE, hues[ph % 5]);
            write_reg(CFG_BT709, ph & 1);
            write_reg(CFG_MONO, ph == 3);
            random_items(43);
            drain();
        end
        write_reg(CFG_MONO, 0);
        random_items(20);
        drain();

        $display("covered %0d pixels, %0d subpixel beats, hue 0..255, both weight sets, mono",
                 pixel_count, sub_count);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
